### hw/rtl/tcu_pkg.sv
// Shared widths, constants and word types of the triangle circumcircle unit.
package tcu_pkg;

  // Vertex coordinate width (signed integers).
  localparam int unsigned CoordBits = 16;
  // Default number of fraction bits of the fixed-point results.
  localparam int unsigned FracBitsDef = 16;

  // Result widths.
  localparam int unsigned CtrW = 48;
  localparam int unsigned RadW = 63;

  // Edge vector, square, cross product and numerator widths.
  localparam int unsigned AbW   = CoordBits + 1;
  localparam int unsigned SqW   = 2 * CoordBits;
  localparam int unsigned TW    = 2 * CoordBits + 1;
  localparam int unsigned ProdW = 2 * AbW;
  localparam int unsigned DenW  = ProdW + 2;
  localparam int unsigned NumW  = TW + AbW + 1;

  // Depth of the queue between the front and the back.
  localparam int unsigned QDepth   = 8;
  // Number of register stages in the front.
  localparam int unsigned FrontLat = 3;

  // Largest positive center and magnitude of the most negative one.
  localparam logic [CtrW-1:0] CtrPosMax = {1'b0, {(CtrW-1){1'b1}}};
  localparam logic [CtrW-1:0] CtrNegMag = {1'b1, {(CtrW-1){1'b0}}};

  // Input word: the three vertices.
  typedef struct packed {
    logic signed [CoordBits-1:0] ax;
    logic signed [CoordBits-1:0] ay;
    logic signed [CoordBits-1:0] bx;
    logic signed [CoordBits-1:0] by;
    logic signed [CoordBits-1:0] cx;
    logic signed [CoordBits-1:0] cy;
  } tcu_in_t;

  // Result word.
  typedef struct packed {
    logic signed [CtrW-1:0] center_x;
    logic signed [CtrW-1:0] center_y;
    logic [RadW-1:0]        radius_sq;
    logic                   degenerate;
    logic                   saturated;
  } tcu_out_t;

  // Word passed from the front to the back through the queue.
  typedef struct packed {
    logic signed [NumW-1:0]      nx;
    logic signed [NumW-1:0]      ny;
    logic signed [DenW-1:0]      den;
    logic signed [CoordBits-1:0] ax;
    logic signed [CoordBits-1:0] ay;
  } tcu_item_t;

  // Control and sideband that travel alongside the divider.
  typedef struct packed {
    logic                        deg;
    logic                        negx;
    logic                        negy;
    logic                        ovfx;
    logic                        ovfy;
    logic signed [CoordBits-1:0] ax;
    logic signed [CoordBits-1:0] ay;
  } tcu_side_t;

endpackage

### hw/rtl/tcu_front.sv
// Front of the unit: edge vectors, denominator and numerators in three stages.
module tcu_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  tcu_pkg::tcu_in_t    in_i,
  output logic                item_valid_o,
  output tcu_pkg::tcu_item_t  item_o,
  output logic [1:0]          inflight_o
);

  localparam int unsigned C     = tcu_pkg::CoordBits;
  localparam int unsigned AbW   = tcu_pkg::AbW;
  localparam int unsigned SqW   = tcu_pkg::SqW;
  localparam int unsigned TW    = tcu_pkg::TW;
  localparam int unsigned ProdW = tcu_pkg::ProdW;
  localparam int unsigned DenW  = tcu_pkg::DenW;
  localparam int unsigned NumW  = tcu_pkg::NumW;

  logic v1_q, v2_q, v3_q;

  // Stage 1: edge vectors and coordinate squares.
  logic signed [AbW-1:0] abx_d, aby_d, bcx_d, bcy_d;
  logic signed [AbW-1:0] abx1_q, aby1_q, bcx1_q, bcy1_q;
  logic signed [SqW-1:0] ax2_d, ay2_d, bx2_d, by2_d, cx2_d, cy2_d;
  logic signed [SqW-1:0] ax2_q, ay2_q, bx2_q, by2_q, cx2_q, cy2_q;
  logic signed [C-1:0]   ax1_q, ay1_q;

  assign abx_d = AbW'(in_i.bx) - AbW'(in_i.ax);
  assign aby_d = AbW'(in_i.by) - AbW'(in_i.ay);
  assign bcx_d = AbW'(in_i.cx) - AbW'(in_i.bx);
  assign bcy_d = AbW'(in_i.cy) - AbW'(in_i.by);
  assign ax2_d = SqW'(in_i.ax) * SqW'(in_i.ax);
  assign ay2_d = SqW'(in_i.ay) * SqW'(in_i.ay);
  assign bx2_d = SqW'(in_i.bx) * SqW'(in_i.bx);
  assign by2_d = SqW'(in_i.by) * SqW'(in_i.by);
  assign cx2_d = SqW'(in_i.cx) * SqW'(in_i.cx);
  assign cy2_d = SqW'(in_i.cy) * SqW'(in_i.cy);

  // Stage 2: doubled cross product and the two squared-length differences.
  logic signed [ProdW-1:0] p1_d, p2_d;
  logic signed [DenW-1:0]  diff_d, den_d, den2_q, den3_q;
  logic signed [TW-1:0]    tc_d, ta_d, tc_q, ta_q;
  logic signed [AbW-1:0]   abx2_q, aby2_q, bcx2_q, bcy2_q;
  logic signed [C-1:0]     ax2p_q, ay2p_q, ax3_q, ay3_q;

  assign p1_d   = ProdW'(abx1_q) * ProdW'(bcy1_q);
  assign p2_d   = ProdW'(aby1_q) * ProdW'(bcx1_q);
  assign diff_d = DenW'(p1_d) - DenW'(p2_d);
  assign den_d  = diff_d <<< 1;
  assign tc_d   = TW'(cx2_q) + TW'(cy2_q) - TW'(bx2_q) - TW'(by2_q);
  assign ta_d   = TW'(ax2_q) + TW'(ay2_q) - TW'(bx2_q) - TW'(by2_q);

  // Stage 3: the two numerators.
  logic signed [NumW-1:0] nx_d, ny_d, nx_q, ny_q;

  assign nx_d = NumW'(tc_q) * NumW'(abx2_q) + NumW'(ta_q) * NumW'(bcx2_q);
  assign ny_d = NumW'(tc_q) * NumW'(aby2_q) + NumW'(ta_q) * NumW'(bcy2_q);

  // Valid bits of the three stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // Payload registers of the three stages.
  always_ff @(posedge clk_i) begin
    abx1_q <= abx_d;
    aby1_q <= aby_d;
    bcx1_q <= bcx_d;
    bcy1_q <= bcy_d;
    ax2_q  <= ax2_d;
    ay2_q  <= ay2_d;
    bx2_q  <= bx2_d;
    by2_q  <= by2_d;
    cx2_q  <= cx2_d;
    cy2_q  <= cy2_d;
    ax1_q  <= in_i.ax;
    ay1_q  <= in_i.ay;

    den2_q <= den_d;
    tc_q   <= tc_d;
    ta_q   <= ta_d;
    abx2_q <= abx1_q;
    aby2_q <= aby1_q;
    bcx2_q <= bcx1_q;
    bcy2_q <= bcy1_q;
    ax2p_q <= ax1_q;
    ay2p_q <= ay1_q;

    nx_q   <= nx_d;
    ny_q   <= ny_d;
    den3_q <= den2_q;
    ax3_q  <= ax2p_q;
    ay3_q  <= ay2p_q;
  end

  assign item_valid_o = v3_q;
  assign item_o.nx    = nx_q;
  assign item_o.ny    = ny_q;
  assign item_o.den   = den3_q;
  assign item_o.ax    = ax3_q;
  assign item_o.ay    = ay3_q;

  // Number of words still in the front.
  assign inflight_o = {1'b0, v1_q} + {1'b0, v2_q} + {1'b0, v3_q};

endmodule

### hw/rtl/tcu_queue.sv
// Small queue that decouples the front from the back.
module tcu_queue (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    push_i,
  input  tcu_pkg::tcu_item_t                      data_i,
  input  logic                                    pop_i,
  output tcu_pkg::tcu_item_t                      head_o,
  output logic [$clog2(tcu_pkg::QDepth+1)-1:0]    level_o
);

  localparam int unsigned Depth = tcu_pkg::QDepth;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned LvlW  = $clog2(Depth + 1);

  tcu_pkg::tcu_item_t mem_q [Depth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [LvlW-1:0] level_q, level_d;

  // Occupancy follows pushes and pops.
  always_comb begin
    level_d = level_q;
    if (push_i && !pop_i) begin
      level_d = level_q + LvlW'(1);
    end else if (!push_i && pop_i) begin
      level_d = level_q - LvlW'(1);
    end
  end

  // Pointers and occupancy.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      level_q <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rptr_q <= rptr_q + PtrW'(1);
      end
      level_q <= level_d;
    end
  end

  // Storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  assign head_o  = mem_q[rptr_q];
  assign level_o = level_q;

endmodule

### hw/rtl/tcu_div.sv
// Pipelined restoring divider: one quotient bit per stage for both coordinates.
module tcu_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  input  logic [tcu_pkg::DenW-1:0]     d_i,
  input  logic [tcu_pkg::DenW-1:0]     remx_i,
  input  logic [tcu_pkg::CtrW-1:0]     lox_i,
  input  logic [tcu_pkg::DenW-1:0]     remy_i,
  input  logic [tcu_pkg::CtrW-1:0]     loy_i,
  input  tcu_pkg::tcu_side_t           side_i,
  output logic                         valid_o,
  output logic [tcu_pkg::CtrW-1:0]     qx_o,
  output logic [tcu_pkg::CtrW-1:0]     qy_o,
  output tcu_pkg::tcu_side_t           side_o
);

  localparam int unsigned DenW = tcu_pkg::DenW;
  localparam int unsigned CtrW = tcu_pkg::CtrW;

  // Partial remainder and the word that shifts dividend bits out and quotient bits in.
  typedef struct packed {
    logic [DenW-1:0] rem;
    logic [CtrW-1:0] w;
  } div_t;

  function automatic div_t div_step(input div_t cur, input logic [DenW-1:0] d);
    logic [DenW:0] r2;
    div_t          res;
    r2 = {cur.rem, cur.w[CtrW-1]};
    if (r2 >= {1'b0, d}) begin
      res.rem = DenW'(r2 - {1'b0, d});
      res.w   = {cur.w[CtrW-2:0], 1'b1};
    end else begin
      res.rem = r2[DenW-1:0];
      res.w   = {cur.w[CtrW-2:0], 1'b0};
    end
    return res;
  endfunction

  logic               v_q [CtrW];
  logic [DenW-1:0]    d_q [CtrW];
  div_t               x_q [CtrW];
  div_t               y_q [CtrW];
  tcu_pkg::tcu_side_t s_q [CtrW];

  for (genvar k = 0; k < CtrW; k++) begin : g_stage
    logic               v_s;
    logic [DenW-1:0]    d_s;
    div_t               x_s, y_s;
    tcu_pkg::tcu_side_t s_s;

    // Each stage takes the previous stage, the first one the inputs.
    if (k == 0) begin : g_src
      assign v_s = valid_i;
      assign d_s = d_i;
      assign x_s = {remx_i, lox_i};
      assign y_s = {remy_i, loy_i};
      assign s_s = side_i;
    end else begin : g_src
      assign v_s = v_q[k-1];
      assign d_s = d_q[k-1];
      assign x_s = x_q[k-1];
      assign y_s = y_q[k-1];
      assign s_s = s_q[k-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else begin
        v_q[k] <= v_s;
      end
    end

    always_ff @(posedge clk_i) begin
      d_q[k] <= d_s;
      x_q[k] <= div_step(x_s, d_s);
      y_q[k] <= div_step(y_s, d_s);
      s_q[k] <= s_s;
    end
  end

  assign valid_o = v_q[CtrW-1];
  assign qx_o    = x_q[CtrW-1].w;
  assign qy_o    = y_q[CtrW-1].w;
  assign side_o  = s_q[CtrW-1];

endmodule

### hw/rtl/tcu_back.sv
// Back of the unit: division, clipping, squared radius and the result register.
module tcu_back #(
  parameter int unsigned FRAC_BITS = tcu_pkg::FracBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  tcu_pkg::tcu_item_t  item_i,
  output logic                done_o,
  output tcu_pkg::tcu_out_t   res_o
);

  localparam int unsigned C     = tcu_pkg::CoordBits;
  localparam int unsigned DenW  = tcu_pkg::DenW;
  localparam int unsigned NumW  = tcu_pkg::NumW;
  localparam int unsigned CtrW  = tcu_pkg::CtrW;
  localparam int unsigned RadW  = tcu_pkg::RadW;
  localparam int unsigned XW    = NumW + FRAC_BITS;
  localparam int unsigned HiW   = XW - CtrW;
  localparam int unsigned CmpW  = (HiW > DenW) ? HiW : DenW;
  localparam int unsigned MagW  = CtrW + 1;
  localparam int unsigned LoW   = MagW / 2;
  localparam int unsigned HiMW  = MagW - LoW;
  localparam int unsigned LLW   = 2 * LoW;
  localparam int unsigned LHW   = LoW + HiMW;
  localparam int unsigned HHW   = 2 * HiMW;
  localparam int unsigned SqTW  = 2 * MagW;
  localparam int unsigned SumW  = SqTW + 1;

  // Operand set-up: magnitudes, scaled dividends, overflow test, signs.
  logic [NumW-1:0]    magx, magy;
  logic [DenW-1:0]    dmag;
  logic [XW-1:0]      xx, xy;
  logic [CmpW-1:0]    hix, hiy;
  tcu_pkg::tcu_side_t side_d;

  always_comb begin
    magx = item_i.ny[NumW-1] ? -item_i.ny : item_i.ny;
    magy = item_i.nx[NumW-1] ? -item_i.nx : item_i.nx;
    dmag = item_i.den[DenW-1] ? -item_i.den : item_i.den;
    xx   = XW'(magx) << FRAC_BITS;
    xy   = XW'(magy) << FRAC_BITS;
    hix  = CmpW'(xx[XW-1:CtrW]);
    hiy  = CmpW'(xy[XW-1:CtrW]);
    side_d.deg  = (item_i.den == '0);
    side_d.negx = (!item_i.ny[NumW-1] && (item_i.ny != '0)) ^ item_i.den[DenW-1];
    side_d.negy = item_i.nx[NumW-1] ^ item_i.den[DenW-1];
    side_d.ovfx = (hix >= CmpW'(dmag));
    side_d.ovfy = (hiy >= CmpW'(dmag));
    side_d.ax   = item_i.ax;
    side_d.ay   = item_i.ay;
  end

  logic               b0v_q;
  logic [DenW-1:0]    b0d_q, b0rx_q, b0ry_q;
  logic [CtrW-1:0]    b0lx_q, b0ly_q;
  tcu_pkg::tcu_side_t b0s_q;

  always_ff @(posedge clk_i) begin
    b0d_q  <= dmag;
    b0rx_q <= hix[DenW-1:0];
    b0ry_q <= hiy[DenW-1:0];
    b0lx_q <= xx[CtrW-1:0];
    b0ly_q <= xy[CtrW-1:0];
    b0s_q  <= side_d;
  end

  // Quotients of both coordinates.
  logic               dv;
  logic [CtrW-1:0]    qx, qy;
  tcu_pkg::tcu_side_t ds;

  tcu_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (b0v_q),
    .d_i     (b0d_q),
    .remx_i  (b0rx_q),
    .lox_i   (b0lx_q),
    .remy_i  (b0ry_q),
    .loy_i   (b0ly_q),
    .side_i  (b0s_q),
    .valid_o (dv),
    .qx_o    (qx),
    .qy_o    (qy),
    .side_o  (ds)
  );

  // Clip each quotient to the center range and apply the sign.
  logic [CtrW-1:0]        limx, limy, qxc, qyc;
  logic                   clipx, clipy;
  logic signed [CtrW-1:0] px_d, py_d;

  always_comb begin
    limx  = ds.negx ? tcu_pkg::CtrNegMag : tcu_pkg::CtrPosMax;
    limy  = ds.negy ? tcu_pkg::CtrNegMag : tcu_pkg::CtrPosMax;
    clipx = ds.ovfx || (qx > limx);
    clipy = ds.ovfy || (qy > limy);
    qxc   = clipx ? limx : qx;
    qyc   = clipy ? limy : qy;
    px_d  = ds.negx ? -qxc : qxc;
    py_d  = ds.negy ? -qyc : qyc;
  end

  logic                   cv_q, csat_q, cdeg_q;
  logic signed [CtrW-1:0] cpx_q, cpy_q;
  logic signed [C-1:0]    cax_q, cay_q;

  always_ff @(posedge clk_i) begin
    csat_q <= clipx || clipy;
    cdeg_q <= ds.deg;
    cpx_q  <= px_d;
    cpy_q  <= py_d;
    cax_q  <= ds.ax;
    cay_q  <= ds.ay;
  end

  // Distance from the center to the first vertex, as magnitudes.
  logic signed [MagW-1:0] dx, dy;
  logic [MagW-1:0]        mx_d, my_d;

  always_comb begin
    dx   = MagW'(cpx_q) - (MagW'(cax_q) <<< FRAC_BITS);
    dy   = MagW'(cpy_q) - (MagW'(cay_q) <<< FRAC_BITS);
    mx_d = dx[MagW-1] ? -dx : dx;
    my_d = dy[MagW-1] ? -dy : dy;
  end

  logic                   mv_q, msat_q, mdeg_q;
  logic [MagW-1:0]        mx_q, my_q;
  logic signed [CtrW-1:0] mpx_q, mpy_q;

  always_ff @(posedge clk_i) begin
    msat_q <= csat_q;
    mdeg_q <= cdeg_q;
    mx_q   <= mx_d;
    my_q   <= my_d;
    mpx_q  <= cpx_q;
    mpy_q  <= cpy_q;
  end

  // Partial products of the two squares.
  logic [LLW-1:0]         xll_d, yll_d, xll_q, yll_q;
  logic [LHW-1:0]         xlh_d, ylh_d, xlh_q, ylh_q;
  logic [HHW-1:0]         xhh_d, yhh_d, xhh_q, yhh_q;
  logic                   pv_q, psat_q, pdeg_q;
  logic signed [CtrW-1:0] ppx_q, ppy_q;

  assign xll_d = LLW'(mx_q[LoW-1:0]) * LLW'(mx_q[LoW-1:0]);
  assign xlh_d = LHW'(mx_q[LoW-1:0]) * LHW'(mx_q[MagW-1:LoW]);
  assign xhh_d = HHW'(mx_q[MagW-1:LoW]) * HHW'(mx_q[MagW-1:LoW]);
  assign yll_d = LLW'(my_q[LoW-1:0]) * LLW'(my_q[LoW-1:0]);
  assign ylh_d = LHW'(my_q[LoW-1:0]) * LHW'(my_q[MagW-1:LoW]);
  assign yhh_d = HHW'(my_q[MagW-1:LoW]) * HHW'(my_q[MagW-1:LoW]);

  always_ff @(posedge clk_i) begin
    xll_q  <= xll_d;
    xlh_q  <= xlh_d;
    xhh_q  <= xhh_d;
    yll_q  <= yll_d;
    ylh_q  <= ylh_d;
    yhh_q  <= yhh_d;
    psat_q <= msat_q;
    pdeg_q <= mdeg_q;
    ppx_q  <= mpx_q;
    ppy_q  <= mpy_q;
  end

  // Recombine the partial products into the two squares.
  logic [SqTW-1:0]        sqx_d, sqy_d, sqx_q, sqy_q;
  logic                   sv_q, ssat_q, sdeg_q;
  logic signed [CtrW-1:0] spx_q, spy_q;

  assign sqx_d = (SqTW'(xhh_q) << LLW) + (SqTW'(xlh_q) << (LoW + 1)) + SqTW'(xll_q);
  assign sqy_d = (SqTW'(yhh_q) << LLW) + (SqTW'(ylh_q) << (LoW + 1)) + SqTW'(yll_q);

  always_ff @(posedge clk_i) begin
    sqx_q  <= sqx_d;
    sqy_q  <= sqy_d;
    ssat_q <= psat_q;
    sdeg_q <= pdeg_q;
    spx_q  <= ppx_q;
    spy_q  <= ppy_q;
  end

  // Sum, drop the extra fraction bits, clip, and form the result word.
  logic [SumW-1:0]   sum;
  logic              over;
  tcu_pkg::tcu_out_t res_d, res_q;
  logic              done_q;

  always_comb begin
    sum  = SumW'(sqx_q) + SumW'(sqy_q);
    over = |sum[SumW-1:RadW+FRAC_BITS];
    if (sdeg_q) begin
      res_d.center_x   = '0;
      res_d.center_y   = '0;
      res_d.radius_sq  = '0;
      res_d.degenerate = 1'b1;
      res_d.saturated  = 1'b0;
    end else begin
      res_d.center_x   = spx_q;
      res_d.center_y   = spy_q;
      res_d.radius_sq  = over ? {RadW{1'b1}} : sum[FRAC_BITS +: RadW];
      res_d.degenerate = 1'b0;
      res_d.saturated  = ssat_q || over;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  // Valid bits along the back.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b0v_q  <= 1'b0;
      cv_q   <= 1'b0;
      mv_q   <= 1'b0;
      pv_q   <= 1'b0;
      sv_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      b0v_q  <= in_valid_i;
      cv_q   <= dv;
      mv_q   <= cv_q;
      pv_q   <= mv_q;
      sv_q   <= pv_q;
      done_q <= sv_q;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

### hw/rtl/triangle_circumcircle_unit_core.sv
// Top level of the triangle circumcircle unit: front, queue and back.
//
// Takes one triangle per clock (start_i while busy_o is low) and returns one
// result word per triangle, in order, after three front stages, the queue, one
// set-up stage, 48 divider stages (one quotient bit each) and five stages for
// clipping and the squared radius. Each result is shown on res_o for the single
// cycle in which done_o is high and cannot be held off, so the receiver must
// take it then. busy_o rises only when the queue and the front together could
// not absorb another word; with the back draining one word per cycle it stays
// low under continuous input.
module triangle_circumcircle_unit_core #(
  parameter int unsigned FRAC_BITS = tcu_pkg::FracBitsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  tcu_pkg::tcu_in_t  item_i,
  output logic              busy_o,
  output logic              done_o,
  output tcu_pkg::tcu_out_t res_o
);

  localparam int unsigned LvlW = $clog2(tcu_pkg::QDepth + 1);

  logic               accept;
  logic               fv;
  tcu_pkg::tcu_item_t fitem, head;
  logic [1:0]         inflight;
  logic [LvlW-1:0]    level;
  logic               pop;
  logic [LvlW:0]      occ;

  // Words in flight plus words queued must leave room for one more.
  assign occ    = (LvlW+1)'(level) + (LvlW+1)'(inflight);
  assign busy_o = (occ >= (LvlW+1)'(tcu_pkg::QDepth));
  assign accept = start_i && !busy_o;
  assign pop    = (level != '0);

  tcu_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (accept),
    .in_i         (item_i),
    .item_valid_o (fv),
    .item_o       (fitem),
    .inflight_o   (inflight)
  );

  tcu_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fv),
    .data_i  (fitem),
    .pop_i   (pop),
    .head_o  (head),
    .level_o (level)
  );

  tcu_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (pop),
    .item_i     (head),
    .done_o     (done_o),
    .res_o      (res_o)
  );

endmodule

### sim/triangle_circumcircle_unit_checker.sv
// Checker of the triangle circumcircle unit: predicts each result word and compares.
module triangle_circumcircle_unit_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              busy_i,
  input  tcu_pkg::tcu_in_t  item_i,
  input  logic              done_i,
  input  tcu_pkg::tcu_out_t res_i,
  output int                fail_count_o,
  output int                pending_o,
  output int                degen_seen_o,
  output int                sat_seen_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Frac = tcu_pkg::FracBitsDef;

  tcu_pkg::tcu_out_t circle_queue[$];

  // Fixed-point quotient (num * 2^Frac) / den, truncated toward zero and clipped to 48 bits.
  function automatic logic signed [tcu_pkg::CtrW-1:0] center_quot(
      input logic signed [127:0] num, input logic signed [63:0] den, inout logic sat);
    logic [127:0] mag_n, mag_d, q;
    logic neg;
    logic [127:0] lim;
    begin
      neg   = (num < 0) != (den < 0);
      mag_n = (num < 0) ? -num : num;
      mag_d = (den < 0) ? -den : den;
      q     = (mag_n << Frac) / mag_d;
      lim   = neg ? (128'd1 << 47) : ((128'd1 << 47) - 1);
      if (q > lim) begin
        q   = lim;
        sat = 1'b1;
      end
      center_quot = neg ? -q[tcu_pkg::CtrW-1:0] : q[tcu_pkg::CtrW-1:0];
    end
  endfunction

  // Circumcenter and squared radius of one triangle.
  function automatic tcu_pkg::tcu_out_t circle_of(input tcu_pkg::tcu_in_t t);
    logic signed [63:0] ax, ay, bx, by, cx, cy, abx, aby, bcx, bcy, den, bsq, tc, ta;
    logic signed [127:0] nx, ny, dx, dy;
    logic [127:0] rs;
    logic sat;
    tcu_pkg::tcu_out_t r;
    begin
      ax = t.ax; ay = t.ay; bx = t.bx; by = t.by; cx = t.cx; cy = t.cy;
      abx = bx - ax; aby = by - ay; bcx = cx - bx; bcy = cy - by;
      den = 2 * (abx * bcy - aby * bcx);
      r = '0;
      sat = 1'b0;
      if (den == 0) begin
        r.degenerate = 1'b1;
      end else begin
        bsq = bx * bx + by * by;
        tc  = cx * cx + cy * cy - bsq;
        ta  = ax * ax + ay * ay - bsq;
        nx  = 128'(tc) * 128'(abx) + 128'(ta) * 128'(bcx);
        ny  = 128'(tc) * 128'(aby) + 128'(ta) * 128'(bcy);
        r.center_x = center_quot(-ny, den, sat);
        r.center_y = center_quot(nx, den, sat);
        dx = 128'(r.center_x) - (128'(ax) <<< Frac);
        dy = 128'(r.center_y) - (128'(ay) <<< Frac);
        rs = 128'(dx * dx + dy * dy) >> Frac;
        if (rs > {65'd0, {63{1'b1}}}) begin
          rs  = {65'd0, {63{1'b1}}};
          sat = 1'b1;
        end
        r.radius_sq = rs[tcu_pkg::RadW-1:0];
      end
      r.saturated = sat;
      circle_of = r;
    end
  endfunction

  // Predict on each accepted triangle, compare each result word with the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin
    tcu_pkg::tcu_out_t exp_w;
    if (!rst_ni) begin
      fail_count_o <= 0;
      pending_o    <= 0;
      degen_seen_o <= 0;
      sat_seen_o   <= 0;
    end else begin
      if (done_i) begin
        if (circle_queue.size() == 0) begin
          $display("%0t: unexpected result word %h", $time, res_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_w = circle_queue.pop_front();
          if (res_i.degenerate) degen_seen_o <= degen_seen_o + 1;
          if (res_i.saturated) sat_seen_o <= sat_seen_o + 1;
          if (res_i.center_x !== exp_w.center_x || res_i.center_y !== exp_w.center_y ||
              res_i.radius_sq !== exp_w.radius_sq || res_i.degenerate !== exp_w.degenerate ||
              res_i.saturated !== exp_w.saturated) begin
            $display("%0t: mismatch expected cx=%0d cy=%0d r2=%0d deg=%b sat=%b", $time,
                     exp_w.center_x, exp_w.center_y, exp_w.radius_sq, exp_w.degenerate,
                     exp_w.saturated);
            $display("%0t:          actual   cx=%0d cy=%0d r2=%0d deg=%b sat=%b", $time,
                     res_i.center_x, res_i.center_y, res_i.radius_sq, res_i.degenerate,
                     res_i.saturated);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (start_i && !busy_i) circle_queue.push_back(circle_of(item_i));
      // Number of predictions still waiting for their result word.
      pending_o <= circle_queue.size();
    end
  end
endmodule

### sim/triangle_circumcircle_unit_core_tb.sv
// Testbench top of the triangle circumcircle unit: clock, reset, stimulus and verdict.
module triangle_circumcircle_unit_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumRandom = 1100;
  localparam int Latency   = 80;
  localparam longint CycleLimit = 200000;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start_i = 1'b0;
  tcu_pkg::tcu_in_t  item_i = '0;
  logic              busy_o, done_o;
  tcu_pkg::tcu_out_t res_o;
  int                fail_count, pending, degen_seen, sat_seen;
  longint            cycles = 0;
  int                sent = 0;

  triangle_circumcircle_unit_core i_dut (
    .clk_i, .rst_ni, .start_i, .item_i, .busy_o, .done_o, .res_o
  );

  triangle_circumcircle_unit_checker i_checker (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o), .item_i, .done_i(done_o), .res_i(res_o),
    .fail_count_o(fail_count), .pending_o(pending), .degen_seen_o(degen_seen),
    .sat_seen_o(sat_seen)
  );

  // Clock with a 10 ns period.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Cycle counter that ends a hung run.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Hold one triangle word until it is taken, then drop start unless another follows.
  task automatic send_word(input tcu_pkg::tcu_in_t w, input bit keep);
    begin
      start_i <= 1'b1;
      item_i  <= w;
      do @(posedge clk_i); while (busy_o);
      sent++;
      @(negedge clk_i);
      if (!keep) start_i <= 1'b0;
    end
  endtask

  // Random coordinate: mostly small, sometimes full range or an extreme.
  function automatic logic [15:0] rand_coord();
    case ($urandom_range(0, 5))
      0: rand_coord = 16'($urandom());
      1: rand_coord = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
      default: rand_coord = 16'($signed($urandom_range(0, 400)) - 200);
    endcase
  endfunction

  function automatic tcu_pkg::tcu_in_t rand_triangle();
    tcu_pkg::tcu_in_t t;
    begin
      t = {rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord()};
      // Now and then make the points collinear or coincident.
      case ($urandom_range(0, 9))
        0: begin t.bx = t.ax; t.by = t.ay; end
        1: begin t.cx = t.bx + (t.bx - t.ax); t.cy = t.by + (t.by - t.ay); end
        default: ;
      endcase
      rand_triangle = t;
    end
  endfunction

  initial begin
    tcu_pkg::tcu_in_t directed[$];
    tcu_pkg::tcu_in_t t;
    // Extremes, right angles, collinear, coincident and a needle that saturates.
    directed.push_back('{0, 0, 4, 0, 0, 4});
    directed.push_back('{0, 0, 0, 0, 0, 0});
    directed.push_back('{1, 1, 2, 2, 3, 3});
    directed.push_back('{-32768, -32768, 32767, 32767, -32768, 32767});
    directed.push_back('{32767, -32768, -32768, 32767, 32767, 32767});
    directed.push_back('{-32768, -32768, -32768, -32768, 32767, 32767});
    directed.push_back('{-32768, 0, 32767, 0, 0, 1});
    directed.push_back('{-32768, 0, 32767, 1, 32767, 0});
    directed.push_back('{0, 0, 1, 0, 0, 1});
    directed.push_back('{0, 0, 0, 1, 1, 0});
    directed.push_back('{32767, 32767, 32767, 32767, 32767, 32767});
    directed.push_back('{-32768, 32767, 32767, -32768, 0, 0});
    directed.push_back('{3, -7, -11, 5, 13, 17});
    directed.push_back('{-1, -1, 1, -1, 0, 32767});
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    foreach (directed[i]) send_word(directed[i], i != directed.size() - 1);
    // Let the pipeline drain fully before random traffic.
    while (pending != 0) @(negedge clk_i);
    for (int n = 0; n < NumRandom; n++) begin
      t = rand_triangle();
      if (n < NumRandom - 150 && $urandom_range(0, 3) == 0) begin
        start_i <= 1'b0;
        repeat ($urandom_range(1, 4)) @(negedge clk_i);
      end
      if (n == NumRandom / 2) begin
        start_i <= 1'b0;
        while (pending != 0) @(negedge clk_i);
      end
      send_word(t, n != NumRandom - 1);
    end
    while (pending != 0) @(negedge clk_i);
    repeat (Latency) @(negedge clk_i);
    $display("Sent %0d triangles: %0d degenerate and %0d saturated results checked.",
             sent, degen_seen, sat_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
